// ----- hdl/crpa_pkg.sv -----
// ----------------------------------------------------------------------------
// crpa_pkg
// Shared types and constants for the rule 150 privacy amplifier: field widths,
// configuration register indexes, transaction codes and the cell control bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crpa_pkg;

   // Fixed field widths of the interface.
   localparam int WORD_BITS     = 64;
   localparam int CA_BITS_W     = 9;
   localparam int GROUP_W       = 11;
   localparam int BLOCK_POS_W   = 10;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 11;

   // Default automaton size and register reset values.
   localparam int MAX_CELLS_DEF = 256;
   localparam int CA_BITS_RESET = 256;
   localparam int GROUP_RESET   = 1;
   localparam int MIN_CELLS     = 2;
   localparam int MAX_GROUP     = 1024;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CA_BITS          = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKS_PER_GROUP = 2'd1;

   // Input transaction kinds.
   localparam logic REQ_SEED = 1'b0;
   localparam logic REQ_KEY  = 1'b1;

   // Control broadcast from the sequencer to every cell of the row.
   typedef struct packed {
      logic seed;     // seed word taken this cycle
      logic key;      // key word taken this cycle
      logic step;     // automaton steps this cycle
      logic use_acc;  // step runs on the accumulator instead of the cells
   } crpa_ctrl_type;

endpackage : crpa_pkg

`default_nettype wire

// ----- hdl/crpa_cell.sv -----
// ----------------------------------------------------------------------------
// crpa_cell
// One automaton cell with its accumulator bit. Folds masked key bits into the
// accumulator, loads seed bits and applies rule 150 to itself and neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crpa_cell import crpa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  crpa_ctrl_type ctrl,
   input  logic          word_hit,
   input  logic          active,
   input  logic          data_bit,
   input  logic          left_bit,
   input  logic          right_bit,
   output logic          src_bit,
   output logic          acc_next
);

   logic ca_ff;
   logic ca_in;
   logic acc_ff;

   // Accumulator: cleared by a seed, updated by the matching key word.
   always_comb begin
      if (ctrl.seed) begin
         acc_next = 1'b0;
      end else if (ctrl.key && word_hit) begin
         acc_next = acc_ff ^ (data_bit & ca_ff & active);
      end else begin
         acc_next = acc_ff;
      end
   end

   // The value this cell shows its neighbors for a step.
   assign src_bit = ctrl.use_acc ? acc_next : ca_ff;

   // Automaton bit: seed load, rule 150 step, or hold. Inactive cells clear.
   always_comb begin
      if (ctrl.seed && word_hit) begin
         ca_in = data_bit & active;
      end else if (ctrl.step) begin
         ca_in = active & (left_bit ^ src_bit ^ right_bit);
      end else begin
         ca_in = ca_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ca_ff  <= 1'b0;
         acc_ff <= 1'b0;
      end else begin
         ca_ff  <= ca_in;
         acc_ff <= acc_next;
      end
   end

endmodule : crpa_cell

`default_nettype wire

// ----- hdl/crpa_out_queue.sv -----
// ----------------------------------------------------------------------------
// crpa_out_queue
// Output block buffer. Loads a whole accumulator snapshot at once and shifts
// it out one word per response transaction, flagging the final word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crpa_out_queue import crpa_pkg::*; #(
   parameter int DEPTH = 4,
   parameter int WIDTH = WORD_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  logic [$clog2(DEPTH+1)-1:0]       load_count,
   input  logic [DEPTH-1:0][WIDTH-1:0]      load_words,
   output logic                             free,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [WIDTH-1:0]                 rsp_word,
   output logic                             rsp_last
);

   localparam int CNT_W = $clog2(DEPTH+1);

   logic [DEPTH-1:0][WIDTH-1:0] buf_ff;
   logic [DEPTH-1:0][WIDTH-1:0] buf_in;
   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            count_in;
   logic                        pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_word  = buf_ff[0];
   assign rsp_last  = (count_ff == CNT_W'(1));
   assign pop       = rsp_valid && rsp_ready;

   // Room for a new block once the last word of the current one leaves.
   assign free = (count_ff == '0) || (rsp_last && rsp_ready);

   // Load a snapshot, or shift toward the head on each pop.
   always_comb begin
      buf_in   = buf_ff;
      count_in = count_ff;
      if (load) begin
         buf_in   = load_words;
         count_in = load_count;
      end else if (pop) begin
         for (int k = 0; k < DEPTH - 1; k++) begin
            buf_in[k] = buf_ff[k+1];
         end
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule : crpa_out_queue

`default_nettype wire

// ----- hdl/ca_rule150_privacy_amplifier_top.sv -----
// ----------------------------------------------------------------------------
// ca_rule150_privacy_amplifier_top
// Throughput: one request transaction per cycle, seed or key, while req_ready is
//   high. Each key word updates its accumulator slice and a block's last word
//   steps the cell row. A group-ending key word puts its first output word on
//   rsp_ the next cycle; words then leave one per cycle while rsp_ready is high.
// req_ready drops only for a possible group end while the output buffer holds
//   words, unless its final word leaves in that same cycle. Reset is synchronous:
//   cells, accumulator and positions clear, ca_bits returns to 256 and
//   blocks_per_group to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ca_rule150_privacy_amplifier_top import crpa_pkg::*; #(
   parameter int MAX_CELLS = MAX_CELLS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_type,
   input  logic [WORD_BITS-1:0]  req_data_word,
   // Response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [WORD_BITS-1:0]  rsp_hash_word,
   output logic                  rsp_last_word,
   // Configuration channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int MAX_WORDS   = (MAX_CELLS + WORD_BITS - 1) / WORD_BITS;
   localparam int WIW         = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int NWW         = $clog2(MAX_WORDS + 1);
   localparam int CW_RAW      = $clog2(MAX_CELLS + 1);
   localparam int CW          = (CW_RAW > CA_BITS_W) ? CW_RAW : CA_BITS_W;
   localparam int CIW         = $clog2(MAX_CELLS);
   localparam int CELLS_RESET = (CA_BITS_RESET > MAX_CELLS) ? MAX_CELLS : CA_BITS_RESET;

   // Configuration, held in clamped form.
   logic [CW-1:0]          cells_ff;
   logic [CW-1:0]          cells_in;
   logic [GROUP_W-1:0]     group_ff;
   logic [GROUP_W-1:0]     group_in;
   logic [CW-1:0]          ca_ext;
   logic [GROUP_W-1:0]     grp_raw;

   // Sequencing state.
   logic [WIW-1:0]         wp_ff;
   logic [WIW-1:0]         wp_in;
   logic [BLOCK_POS_W-1:0] bp_ff;
   logic [BLOCK_POS_W-1:0] bp_in;

   logic [NWW-1:0]         words_used;
   logic [CW:0]            words_sum;
   logic [CW-1:0]          last_cell;
   logic [CIW-1:0]         last_idx;
   logic [WIW-1:0]         wp_eff;
   logic                   block_last;
   logic [BLOCK_POS_W-1:0] bp_inc;
   logic                   group_due;
   logic                   group_end;
   logic                   is_key;
   logic                   in_acc;
   logic                   q_free;
   crpa_ctrl_type          ctrl;

   logic [MAX_WORDS-1:0]                word_hit;
   logic [MAX_CELLS-1:0]                src;
   logic [MAX_CELLS-1:0]                acc_next;
   logic [MAX_WORDS-1:0][WORD_BITS-1:0] acc_words;
   logic                                wrap_bit;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;
   assign ca_ext    = CW'(csr_wdata[CA_BITS_W-1:0]);
   assign grp_raw   = csr_wdata[GROUP_W-1:0];

   always_comb begin
      cells_in = cells_ff;
      group_in = group_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CA_BITS: begin
               if (ca_ext < CW'(MIN_CELLS)) begin
                  cells_in = CW'(MIN_CELLS);
               end else if (ca_ext > CW'(MAX_CELLS)) begin
                  cells_in = CW'(MAX_CELLS);
               end else begin
                  cells_in = ca_ext;
               end
            end
            CSR_BLOCKS_PER_GROUP: begin
               if (grp_raw == '0) begin
                  group_in = GROUP_W'(1);
               end else if (grp_raw > GROUP_W'(MAX_GROUP)) begin
                  group_in = GROUP_W'(MAX_GROUP);
               end else begin
                  group_in = grp_raw;
               end
            end
            default: begin
               cells_in = cells_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_ff <= CW'(CELLS_RESET);
         group_ff <= GROUP_W'(GROUP_RESET);
      end else begin
         cells_ff <= cells_in;
         group_ff <= group_in;
      end
   end

   // Derived sizes: words in use and the index of the wraparound cell.
   assign words_sum  = {1'b0, cells_ff} + (CW+1)'(WORD_BITS - 1);
   assign words_used = NWW'(words_sum >> $clog2(WORD_BITS));
   assign last_cell  = cells_ff - CW'(1);
   assign last_idx   = last_cell[CIW-1:0];

   // Word and block position of the incoming transaction.
   assign wp_eff     = (NWW'(wp_ff) >= words_used) ? '0 : wp_ff;
   assign block_last = (NWW'(wp_eff) == (words_used - NWW'(1)));
   assign bp_inc     = bp_ff + BLOCK_POS_W'(1);
   assign group_due  = ({1'b0, bp_inc} >= group_ff) || (bp_inc == '0);
   assign is_key     = (req_type == REQ_KEY);
   assign group_end  = is_key && block_last && group_due;

   // Hold off only when this transaction could end a group and the buffer is busy.
   assign req_ready  = !(block_last && group_due) || q_free;
   assign in_acc     = req_valid && req_ready;

   always_comb begin
      ctrl.seed    = in_acc && !is_key;
      ctrl.key     = in_acc && is_key;
      ctrl.step    = in_acc && is_key && block_last;
      ctrl.use_acc = group_end;
   end

   always_comb begin
      wp_in = wp_ff;
      bp_in = bp_ff;
      if (in_acc) begin
         wp_in = block_last ? '0 : WIW'(NWW'(wp_eff) + NWW'(1));
         if (!is_key) begin
            bp_in = '0;
         end else if (block_last) begin
            bp_in = group_due ? '0 : bp_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         bp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         bp_ff <= bp_in;
      end
   end

   // Word select for the row.
   always_comb begin
      for (int w = 0; w < MAX_WORDS; w++) begin
         word_hit[w] = (wp_eff == WIW'(w));
      end
   end

   // The cell holding the highest active index closes the ring.
   assign wrap_bit = src[last_idx];

   // Row of cells with ring neighbors.
   for (genvar i = 0; i < MAX_CELLS; i++) begin : g_cell
      logic left_bit;
      logic right_bit;

      if (i == 0) begin : g_left_wrap
         assign left_bit = wrap_bit;
      end else begin : g_left
         assign left_bit = src[i-1];
      end

      if (i == MAX_CELLS - 1) begin : g_right_wrap
         assign right_bit = src[0];
      end else begin : g_right
         assign right_bit = (last_idx == CIW'(i)) ? src[0] : src[i+1];
      end

      crpa_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .word_hit  (word_hit[i / WORD_BITS]),
         .active    (CW'(i) < cells_ff),
         .data_bit  (req_data_word[i % WORD_BITS]),
         .left_bit  (left_bit),
         .right_bit (right_bit),
         .src_bit   (src[i]),
         .acc_next  (acc_next[i])
      );
   end

   // Accumulator snapshot as output words.
   for (genvar w = 0; w < MAX_WORDS; w++) begin : g_word
      for (genvar b = 0; b < WORD_BITS; b++) begin : g_bit
         if (w * WORD_BITS + b < MAX_CELLS) begin : g_used
            assign acc_words[w][b] = acc_next[w * WORD_BITS + b];
         end else begin : g_pad
            assign acc_words[w][b] = 1'b0;
         end
      end
   end

   // Output block buffer.
   crpa_out_queue #(
      .DEPTH (MAX_WORDS),
      .WIDTH (WORD_BITS)
   ) u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (in_acc && group_end),
      .load_count (words_used),
      .load_words (acc_words),
      .free       (q_free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_hash_word),
      .rsp_last   (rsp_last_word)
   );

endmodule : ca_rule150_privacy_amplifier_top

`default_nettype wire

// ----- hdl/crpa_checker.sv -----
// ----------------------------------------------------------------------------
// crpa_checker
// Port-level checks for the rule 150 privacy amplifier, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crpa_checker import crpa_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 req_type,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [WORD_BITS-1:0] rsp_hash_word,
   input logic                 rsp_last_word
);

   // A stalled response keeps its word and flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash_word)
                                  && $stable(rsp_last_word))
      else $error("stalled response changed");

   // Nothing is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response pending after reset");

   // An output block is not cut short before its last word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_word |=> rsp_valid)
      else $error("output block ended without a last word");

   // Output only starts after a key transaction.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && (req_type == REQ_KEY)))
      else $error("response without a key transaction");

endmodule : crpa_checker

bind ca_rule150_privacy_amplifier_top crpa_checker u_crpa_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_type      (req_type),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_hash_word (rsp_hash_word),
   .rsp_last_word (rsp_last_word)
);

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the rule 150 privacy amplifier. A scoreboard
// class tracks the automaton row, the accumulator and the word and block
// positions, and predicts every output word. Plain tasks drive seed and key
// transactions and register writes. The run starts with directed corners,
// continues with random configurations, adds a long output stall, and
// finishes with one verdict line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import crpa_pkg::*;

   // Register indexes that no register answers to.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   localparam int ROW_BITS     = MAX_CELLS_DEF;
   localparam int DRAIN_CYCLES = 12;
   localparam int STALL_CYCLES = 300;

   typedef struct {
      logic [WORD_BITS-1:0] hash;
      logic                 last;
   } hash_out_type;

   // Tracks the amplifier state and holds the output words still to come.
   class hash_scoreboard;
      logic [ROW_BITS-1:0]    cells;
      logic [ROW_BITS-1:0]    accum;
      logic [CA_BITS_W-1:0]   ca_bits;
      logic [GROUP_W-1:0]     group_reg;
      logic [BLOCK_POS_W-1:0] block_pos;
      int                     word_pos;
      int                     failures;
      hash_out_type           expected_hash[$];

      function new();
         cells     = '0;
         accum     = '0;
         ca_bits   = CA_BITS_W'(CA_BITS_RESET);
         group_reg = GROUP_W'(GROUP_RESET);
         block_pos = '0;
         word_pos  = 0;
         failures  = 0;
      endfunction

      function int cells_in_use();
         int n;
         n = int'(ca_bits);
         if (n < MIN_CELLS) n = MIN_CELLS;
         if (n > ROW_BITS) n = ROW_BITS;
         return n;
      endfunction

      function int words_in_use();
         return (cells_in_use() + WORD_BITS - 1) / WORD_BITS;
      endfunction

      function int group_size();
         int g;
         g = int'(group_reg);
         if (g < 1) g = 1;
         if (g > MAX_GROUP) g = MAX_GROUP;
         return g;
      endfunction

      // Active cells of one word; cells past the width read as zero.
      function logic [WORD_BITS-1:0] active_mask(int w);
         int n;
         int lo;
         logic [WORD_BITS-1:0] ones;
         n    = cells_in_use();
         lo   = w * WORD_BITS;
         ones = '1;
         if (lo >= n) return '0;
         if (n - lo >= WORD_BITS) return ones;
         return ones >> (WORD_BITS - (n - lo));
      endfunction

      // One rule 150 step around the ring; cells past the width are cleared.
      function void step_row();
         logic [ROW_BITS-1:0] nxt;
         int n;
         int i;
         n   = cells_in_use();
         nxt = '0;
         for (i = 0; i < n; i++) begin
            nxt[i] = cells[(i + n - 1) % n] ^ cells[i] ^ cells[(i + 1) % n];
         end
         cells = nxt;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_CA_BITS) ca_bits = data[CA_BITS_W-1:0];
         else if (idx == CSR_BLOCKS_PER_GROUP) group_reg = data[GROUP_W-1:0];
      endfunction

      // Applies one accepted request transaction and queues its output words.
      function void note_request(logic kind, logic [WORD_BITS-1:0] data);
         int nw;
         int wp;
         int k;
         hash_out_type item;
         logic [WORD_BITS-1:0] slice;
         nw = words_in_use();
         wp = word_pos;
         if (wp >= nw) wp = 0;

         if (kind == REQ_SEED) begin
            cells[wp*WORD_BITS +: WORD_BITS] = data & active_mask(wp);
            accum     = '0;
            block_pos = '0;
            wp++;
            word_pos  = (wp >= nw) ? 0 : wp;
            return;
         end

         slice = accum[wp*WORD_BITS +: WORD_BITS];
         slice = slice ^ (data & cells[wp*WORD_BITS +: WORD_BITS] & active_mask(wp));
         accum[wp*WORD_BITS +: WORD_BITS] = slice;
         wp++;
         if (wp < nw) begin
            word_pos = wp;
            return;
         end

         // End of a block: step the row, then close the group if it is full.
         word_pos = 0;
         step_row();
         block_pos = block_pos + 1'b1;
         if (int'(block_pos) >= group_size() || block_pos == '0) begin
            for (k = 0; k < nw; k++) begin
               item.hash = accum[k*WORD_BITS +: WORD_BITS];
               item.last = (k + 1 == nw);
               expected_hash.insert(expected_hash.size(), item);
            end
            cells = accum;
            step_row();
            block_pos = '0;
         end
      endfunction

      // Compares one output transaction with the oldest expected word.
      function void check_hash(logic [WORD_BITS-1:0] hash, logic last);
         hash_out_type item;
         if (expected_hash.size() == 0) begin
            $error("unexpected output: hash_word %h, last_word %b", hash, last);
            failures++;
            return;
         end
         item = expected_hash.pop_front();
         if (hash !== item.hash) begin
            $error("hash_word mismatch: expected %h, actual %h", item.hash, hash);
            failures++;
         end
         if (last !== item.last) begin
            $error("last_word mismatch: expected %b, actual %b", item.last, last);
            failures++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_type = REQ_SEED;
   logic [WORD_BITS-1:0]  req_data_word = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [WORD_BITS-1:0]  rsp_hash_word;
   logic                  rsp_last_word;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_CA_BITS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   hash_scoreboard sb;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_request = 0;
   int stall_seen = 0;
   int stall_left = 0;

   ca_rule150_privacy_amplifier_top DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_data_word (req_data_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_hash_word (rsp_hash_word),
      .rsp_last_word (rsp_last_word),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #10 clock = ~clock;

   // Output side: random stalls, plus a long hold-off whenever one is requested.
   always @(negedge clock) begin
      if (stall_request != stall_seen) begin
         stall_seen = stall_request;
         stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Every output transaction is checked at the edge that accepts it.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_hash(rsp_hash_word, rsp_last_word);
   end

   function logic [WORD_BITS-1:0] random_word();
      int roll;
      roll = $urandom_range(99);
      if (roll < 5) return '1;
      if (roll < 10) return '0;
      return {$urandom, $urandom};
   endfunction

   // Offers one request transaction and waits until it is accepted.
   task automatic send_request(logic kind, logic [WORD_BITS-1:0] data);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_data_word <= data;
      do @(posedge clock); while (!req_ready);
      sb.note_request(kind, data);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stops offering requests until every expected word is out and the block is quiet.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_hash.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(int cells, int group);
      write_csr(CSR_CA_BITS, CSR_DATA_W'(cells));
      write_csr(CSR_BLOCKS_PER_GROUP, CSR_DATA_W'(group));
   endtask

   task automatic pick_config();
      int cells;
      int group;
      int roll;
      roll = $urandom_range(99);
      if (roll < 60) cells = $urandom_range(64, 2);
      else if (roll < 85) cells = $urandom_range(256, 65);
      else cells = $urandom_range(2047, 0);
      roll = $urandom_range(99);
      if (roll < 70) group = $urandom_range(3, 0);
      else if (roll < 90) group = $urandom_range(8, 4);
      else group = $urandom_range(2047, 0);
      set_config(cells, group);
   endtask

   // Mostly whole seed loads and key blocks, with stray transactions mixed in.
   task automatic run_random_stream(int count, int noise_pct);
      int issued;
      int nw;
      int w;
      int roll;
      issued = 0;
      while (issued < count) begin
         nw   = sb.words_in_use();
         roll = $urandom_range(99);
         if (roll < noise_pct) begin
            send_request(($urandom_range(1) == 1) ? REQ_KEY : REQ_SEED, random_word());
            issued++;
         end else if (roll < noise_pct + 20 || issued == 0) begin
            for (w = 0; w < nw; w++) send_request(REQ_SEED, random_word());
            issued += nw;
         end else begin
            for (w = 0; w < nw; w++) send_request(REQ_KEY, random_word());
            issued += nw;
         end
      end
   endtask

   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int i;
      sb = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 23;
      recv_idle_pct = 64;

      // Keys before any seed see an all-zero row and give zero words.
      send_request(REQ_KEY, '1);
      send_request(REQ_KEY, '0);
      send_request(REQ_KEY, 64'h5555_5555_5555_5555);
      send_request(REQ_KEY, 64'haaaa_aaaa_aaaa_aaaa);
      send_request(REQ_SEED, '1);
      send_request(REQ_SEED, 64'haaaa_aaaa_aaaa_aaaa);
      send_request(REQ_SEED, 64'h8000_0000_0000_0001);
      send_request(REQ_SEED, random_word());
      for (i = 0; i < 4; i++) send_request(REQ_KEY, '1);
      wait_idle();

      // Unmapped indexes, smallest row and a zero group size.
      write_csr(CSR_SPARE_2, '1);
      write_csr(CSR_SPARE_3, '0);
      set_config(2, 0);
      send_request(REQ_SEED, '1);
      send_request(REQ_KEY, '1);
      send_request(REQ_KEY, 64'h2);
      wait_idle();
      set_config(1, 0);
      send_request(REQ_SEED, 64'h2);
      send_request(REQ_KEY, '1);
      wait_idle();
      set_config(0, 1);
      send_request(REQ_KEY, '1);
      wait_idle();

      // One cell spills into a second word.
      set_config(65, 1);
      send_request(REQ_SEED, '1);
      send_request(REQ_SEED, '1);
      send_request(REQ_KEY, '1);
      send_request(REQ_KEY, '1);
      wait_idle();

      // Shrinking the row mid-block restarts the word position, and a smaller
      // group size than the blocks already taken closes the group at once.
      set_config(128, 5);
      send_request(REQ_SEED, random_word());
      send_request(REQ_SEED, random_word());
      for (i = 0; i < 7; i++) send_request(REQ_KEY, random_word());
      wait_idle();
      set_config(64, 2);
      send_request(REQ_KEY, random_word());
      wait_idle();

      // Random configurations under three idle patterns.
      for (i = 0; i < 12; i++) begin
         if (i == 4) begin
            send_idle_pct = 64;
            recv_idle_pct = 23;
         end else if (i == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         pick_config();
         run_random_stream(8, 10);
         wait_idle();
      end

      // Output held off for a long stretch while keys keep coming.
      set_config(2047, 1);
      for (i = 0; i < 4; i++) send_request(REQ_SEED, random_word());
      stall_request++;
      for (i = 0; i < 16; i++) send_request(REQ_KEY, random_word());
      wait_idle();

      repeat (20) @(posedge clock);
      if (sb.failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/crpa_pkg.sv
hdl/crpa_cell.sv
hdl/crpa_out_queue.sv
hdl/ca_rule150_privacy_amplifier_top.sv
hdl/crpa_checker.sv
dv/tb.sv
